@@ src/ssweep_pkg.sv @@
// Shared constants, types and sine table builder for the stepped sine sweep.
package ssweep_pkg;

	localparam int PHASE_BITS  = 32;
	localparam int TABLE_BITS  = 10;
	localparam int SAMPLE_BITS = 16;

	localparam int INC_BITS    = 32;
	localparam int GROWTH_BITS = 18;
	localparam int FRAC_BITS   = 16;
	localparam int COUNT_BITS  = 16;
	localparam int PROD_BITS   = INC_BITS + GROWTH_BITS;
	localparam int NEXT_BITS   = PROD_BITS - FRAC_BITS;
	localparam int CFG_BITS    = 32;
	localparam int CFG_IDX_BITS = 2;
	localparam int TABLE_DEPTH = 1 << TABLE_BITS;
	localparam int MAG_BITS    = SAMPLE_BITS - 1;
	localparam int SUM_BITS    = (PHASE_BITS > INC_BITS) ? PHASE_BITS : INC_BITS;

	// register indexes on the config port
	localparam logic [CFG_IDX_BITS-1:0] CFG_START_INC  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_STOP_INC   = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_GROWTH     = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_STEP_LEN   = 2'd3;

	localparam logic [INC_BITS-1:0]    RST_START_INC = 32'd1789570;
	localparam logic [INC_BITS-1:0]    RST_STOP_INC  = 32'd1789569707;
	localparam logic [GROWTH_BITS-1:0] RST_GROWTH    = 18'd72090;
	localparam logic [COUNT_BITS-1:0]  RST_STEP_LEN  = 16'd1024;

	// pi/2 in Q30
	localparam longint unsigned PIH_Q30 = 64'd1686629713;

	typedef logic [MAG_BITS-1:0] sine_rom_t [TABLE_DEPTH];

	// Quarter-wave table: entry k = round(A * sin(angle at center of bin k)),
	// sine by Taylor series to x^15 in Q30, evaluated at elaboration.
	function automatic sine_rom_t build_sine_rom();
		sine_rom_t rom;
		longint unsigned amp;
		longint unsigned x;
		longint unsigned term;
		longint unsigned sum;
		longint unsigned v;
		amp = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
		for (int k = 0; k < TABLE_DEPTH; k++) begin
			x = (PIH_Q30 * (2 * longint'(k) + 1)) >> (TABLE_BITS + 1);
			term = x;
			sum = x;
			for (int n = 1; n <= 7; n++) begin
				term = (term * x) >> 30;
				term = (term * x) >> 30;
				// divide by (2n)(2n+1)
				case (n)
					1: term = term / 64'd6;
					2: term = term / 64'd20;
					3: term = term / 64'd42;
					4: term = term / 64'd72;
					5: term = term / 64'd110;
					6: term = term / 64'd156;
					default: term = term / 64'd210;
				endcase
				if ((n & 1) == 1)
					sum = sum - term;
				else
					sum = sum + term;
			end
			v = (sum * amp + (64'd1 << 29)) >> 30;
			if (v > amp)
				v = amp;
			rom[k] = v[MAG_BITS-1:0];
		end
		return rom;
	endfunction

endpackage

@@ src/stepped_sine_sweep_phase_accumulator_top.sv @@
// Stepped logarithmic sine sweep: phase accumulator, step control and sine table output.
//
// One input word (restart flag) yields one output word (sample, active, last).
// A word is taken every cycle unless back-pressure from out_ready drops in_ready;
// the phase/increment update, including the 32x18 growth multiply and end-of-sweep
// compare, settles in the accept cycle. The quarter-wave table is a registered ROM
// read from the first stage that feeds the output register directly, and the output sign is applied there.
// The output stage and the first stage each hold one word, so while a result
// waits on out_ready one more word is taken, then in_ready drops. Config writes
// take effect on the state only through restart (start_increment) or at the
// next step boundary; stop_increment is compared on every word.
module stepped_sine_sweep_phase_accumulator_top (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     cfg_we,
	input  logic [ssweep_pkg::CFG_IDX_BITS-1:0]      cfg_index,
	input  logic [ssweep_pkg::CFG_BITS-1:0]          cfg_data,
	input  logic                                     in_valid,
	output logic                                     in_ready,
	input  logic                                     restart,
	output logic                                     out_valid,
	input  logic                                     out_ready,
	output logic signed [ssweep_pkg::SAMPLE_BITS-1:0] sample,
	output logic                                     active,
	output logic                                     last
);

	localparam int PB = ssweep_pkg::PHASE_BITS;
	localparam int TB = ssweep_pkg::TABLE_BITS;
	localparam int IB = ssweep_pkg::INC_BITS;
	localparam int GB = ssweep_pkg::GROWTH_BITS;
	localparam int CB = ssweep_pkg::COUNT_BITS;
	localparam int XB = ssweep_pkg::PROD_BITS;
	localparam int NB = ssweep_pkg::NEXT_BITS;
	localparam int SB = ssweep_pkg::SUM_BITS;
	localparam int MB = ssweep_pkg::MAG_BITS;

	localparam ssweep_pkg::sine_rom_t SINE_ROM = ssweep_pkg::build_sine_rom();

	// config registers
	logic [IB-1:0] start_inc_q;
	logic [IB-1:0] stop_inc_q;
	logic [GB-1:0] growth_q;
	logic [CB-1:0] step_len_q;

	// sweep state
	logic [PB-1:0] phase_q;
	logic [IB-1:0] inc_q;
	logic [CB-1:0] count_q;
	logic          running_q;

	// pipeline
	logic          v_s1;
	logic [TB-1:0] k_s1;
	logic          neg_s1;
	logic          act_s1;
	logic          last_s1;
	logic          v_s2;
	logic [MB-1:0] mag_s2;
	logic          neg_s2;
	logic          act_s2;
	logic          last_s2;

	logic          s1_en;
	logic          s2_en;
	logic          take;

	// next-state logic
	logic [PB-1:0] ph0;
	logic [IB-1:0] inc0;
	logic [CB-1:0] cnt0;
	logic          run0;
	logic          live;
	logic [CB-1:0] cnt1;
	logic          boundary;
	logic [XB-1:0] prod;
	logic [NB-1:0] nxt;
	logic          reach;
	logic [IB-1:0] nxt_sat;
	logic [SB-1:0] ph_sum;
	logic [TB+1:0] ph_top;
	logic [TB-1:0] k_d;
	logic [PB-1:0] phase_d;
	logic [IB-1:0] inc_d;
	logic [CB-1:0] count_d;
	logic          running_d;
	logic          last_d;
	logic [ssweep_pkg::SAMPLE_BITS-1:0] mag_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_inc_q <= ssweep_pkg::RST_START_INC;
			stop_inc_q  <= ssweep_pkg::RST_STOP_INC;
			growth_q    <= ssweep_pkg::RST_GROWTH;
			step_len_q  <= ssweep_pkg::RST_STEP_LEN;
		end else if (cfg_we) begin
			case (cfg_index)
				ssweep_pkg::CFG_START_INC: start_inc_q <= cfg_data[IB-1:0];
				ssweep_pkg::CFG_STOP_INC:  stop_inc_q  <= cfg_data[IB-1:0];
				ssweep_pkg::CFG_GROWTH:    growth_q    <= cfg_data[GB-1:0];
				ssweep_pkg::CFG_STEP_LEN:  step_len_q  <= cfg_data[CB-1:0];
				default: ;
			endcase
		end
	end

	assign s2_en    = !v_s2 || out_ready;
	assign s1_en    = !v_s1 || s2_en;
	assign in_ready = s1_en;
	assign take     = in_valid && in_ready;

	always_comb begin
		ph0  = restart ? '0 : phase_q;
		inc0 = restart ? start_inc_q : inc_q;
		cnt0 = restart ? '0 : count_q;
		run0 = restart || running_q;
		live = run0 && (inc0 < stop_inc_q);

		ph_sum  = SB'(ph0) + SB'(inc0);
		ph_top  = ph0[PB-1 -: TB+2];
		k_d     = ph_top[TB] ? ~ph_top[TB-1:0] : ph_top[TB-1:0];

		cnt1     = cnt0 + CB'(1);
		boundary = (cnt1 == '0) || (cnt1 >= step_len_q);
		prod     = XB'(inc0) * XB'(growth_q);
		nxt      = prod[XB-1:ssweep_pkg::FRAC_BITS];
		reach    = nxt >= NB'(stop_inc_q);
		nxt_sat  = (|nxt[NB-1:IB]) ? '1 : nxt[IB-1:0];

		phase_d   = ph0;
		inc_d     = inc0;
		count_d   = cnt0;
		running_d = live;
		last_d    = 1'b0;
		if (live) begin
			phase_d = ph_sum[PB-1:0];
			if (boundary) begin
				count_d = '0;
				if (reach) begin
					last_d    = 1'b1;
					running_d = 1'b0;
				end else begin
					inc_d = nxt_sat;
				end
			end else begin
				count_d = cnt1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= '0;
			inc_q     <= ssweep_pkg::RST_START_INC;
			count_q   <= '0;
			running_q <= 1'b1;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
		end else begin
			if (take) begin
				phase_q   <= phase_d;
				inc_q     <= inc_d;
				count_q   <= count_d;
				running_q <= running_d;
			end
			if (s1_en)
				v_s1 <= in_valid;
			if (s2_en)
				v_s2 <= v_s1;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (take) begin
			k_s1    <= k_d;
			neg_s1  <= live && ph_top[TB+1];
			act_s1  <= live;
			last_s1 <= last_d;
		end
		if (s2_en && v_s1) begin
			mag_s2  <= act_s1 ? SINE_ROM[k_s1] : '0;
			neg_s2  <= neg_s1;
			act_s2  <= act_s1;
			last_s2 <= last_s1;
		end
	end

	assign mag_ext   = {1'b0, mag_s2};
	assign sample    = neg_s2 ? (-mag_ext) : mag_ext;
	assign active    = act_s2;
	assign last      = last_s2;
	assign out_valid = v_s2;

endmodule
